>>> rtl/whp_pkg.sv
`default_nettype none

package whp_pkg;

    // chunk and header tags, first file byte in the top bits
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM        = 16'h0001;
    localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
    localparam logic [15:0] BITS_REQUIRED  = 16'd16;
    localparam logic [31:0] FMT_BODY_LEN   = 32'd16;

    typedef enum logic [3:0] {
        PH_RIFF      = 4'd0,
        PH_FMT_HDR   = 4'd1,
        PH_FMT_SKIP  = 4'd2,
        PH_FMT_BODY  = 4'd3,
        PH_FMT_REST  = 4'd4,
        PH_DATA_HDR  = 4'd5,
        PH_DATA_SKIP = 4'd6,
        PH_PAYLOAD   = 4'd7,
        PH_IDLE      = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        ST_PARSING = 2'd0,
        ST_DONE    = 2'd1,
        ST_FAILED  = 2'd2
    } t_status;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_TRUNCATED = 4'd1;
    localparam logic [3:0] ERR_NOT_RIFF  = 4'd2;
    localparam logic [3:0] ERR_NOT_WAVE  = 4'd3;
    localparam logic [3:0] ERR_FORMAT    = 4'd4;
    localparam logic [3:0] ERR_CHANNELS  = 4'd5;
    localparam logic [3:0] ERR_BITS      = 4'd6;
    localparam logic [3:0] ERR_SHORT_FMT = 4'd7;
    localparam logic [3:0] ERR_ZERO_RATE = 4'd8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic        pcm_valid;
        logic [7:0]  pcm_byte;
        logic        pcm_last;
        t_status     status;
        logic [3:0]  error_code;
        logic [2:0]  num_channels;
        logic [31:0] rate_hz;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/wav_header_parser.sv
// channel   | dir | bus          | contents
// ----------+-----+--------------+------------------------------------------------
// s_axis    | in  | tdata[7:0]   | in_byte
//           |     | tlast        | end_of_file
// m_axis    | out | tdata[55:0]  | pcm_byte, status, error_code, num_channels,
//           |     |              | rate_hz (lowest first), zero filled
//           |     | tuser        | pcm_valid
//           |     | tlast        | pcm_last
//
// one result request per input byte, one byte per cycle sustained while m_axis is ready
// a byte passes the input register, then parse logic into the result register
// the per-byte parse state update is the only loop
// reset (i_rst_n low at a clock edge) returns to the riff header check, status parsing
// a stall on m_axis holds the result; s_axis stays ready while a slot is free
`default_nettype none

module wav_header_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input byte stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire         s_axis_tlast,   // end_of_file
    // parse result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [7:0] pcm_byte, [9:8] status, [13:10] error_code,
                                        // [16:14] num_channels, [48:17] rate_hz
    output logic        m_axis_tuser,   // pcm_valid
    output logic        m_axis_tlast    // pcm_last
);

    whp_pkg::t_in_item in_item;
    whp_pkg::t_in_item stage_item;
    whp_pkg::t_result  core_result;
    whp_pkg::t_result  out_result;
    logic              stage_valid;
    logic              out_ready;
    logic              core_take;

    assign in_item.in_byte     = s_axis_tdata;
    assign in_item.end_of_file = s_axis_tlast;

    // a byte moves through the parser once the result slot can hold its result
    assign core_take = stage_valid && out_ready;

    whp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_take  (core_take),
        .o_item  (stage_item)
    );

    whp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (core_take),
        .i_item   (stage_item),
        .o_result (core_result)
    );

    whp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .o_ready  (out_ready),
        .i_result (core_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    // pack result fields, lowest field first, pad to whole bytes
    assign m_axis_tdata = {7'd0,
                           out_result.rate_hz,
                           out_result.num_channels,
                           out_result.error_code,
                           out_result.status,
                           out_result.pcm_byte};
    assign m_axis_tuser = out_result.pcm_valid;
    assign m_axis_tlast = out_result.pcm_last;

endmodule

`default_nettype wire

>>> rtl/whp_in_stage.sv
`default_nettype none

module whp_in_stage (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  whp_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  wire                i_take,
    output whp_pkg::t_in_item  o_item
);

    logic              r_valid;
    logic              n_valid;
    whp_pkg::t_in_item r_item;
    logic              w_load;

    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> rtl/whp_core.sv
`default_nettype none

module whp_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_take,
    input  whp_pkg::t_in_item  i_item,
    output whp_pkg::t_result   o_result
);

    whp_pkg::t_phase  r_phase,   n_phase;
    whp_pkg::t_status r_verdict, n_verdict;
    logic [4:0]  r_cnt,   n_cnt;
    logic [31:0] r_tag,   n_tag;
    logic [31:0] r_size,  n_size;
    logic [31:0] r_skip,  n_skip;
    logic [31:0] r_pay,   n_pay;
    logic [15:0] r_fmt,   n_fmt;
    logic [15:0] r_ch,    n_ch;
    logic [31:0] r_rate,  n_rate;
    logic [15:0] r_bits,  n_bits;
    logic [3:0]  r_err,   n_err;

    logic        fail_req;
    logic [3:0]  fail_code;
    logic        done_req;
    logic [3:0]  riff_err;
    logic [7:0]  b;

    assign b = i_item.in_byte;

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_verdict = r_verdict;
        n_cnt     = r_cnt;
        n_tag     = r_tag;
        n_size    = r_size;
        n_skip    = r_skip;
        n_pay     = r_pay;
        n_fmt     = r_fmt;
        n_ch      = r_ch;
        n_rate    = r_rate;
        n_bits    = r_bits;
        n_err     = r_err;
        fail_req  = 1'b0;
        fail_code = whp_pkg::ERR_NONE;
        done_req  = 1'b0;
        riff_err  = r_err;

        unique case (r_phase)
            whp_pkg::PH_RIFF: begin
                n_tag = {r_tag[23:0], b};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd3 && n_tag != whp_pkg::TAG_RIFF) begin
                    n_err = whp_pkg::ERR_NOT_RIFF;
                end else if (r_cnt == 5'd11) begin
                    n_cnt = 5'd0;
                    if (r_err == whp_pkg::ERR_NONE && n_tag != whp_pkg::TAG_WAVE) begin
                        riff_err = whp_pkg::ERR_NOT_WAVE;
                    end
                    if (riff_err != whp_pkg::ERR_NONE) begin
                        fail_req  = 1'b1;
                        fail_code = riff_err;
                    end else begin
                        n_phase = whp_pkg::PH_FMT_HDR;
                    end
                end
            end
            whp_pkg::PH_FMT_HDR, whp_pkg::PH_DATA_HDR: begin
                unique case (r_cnt[2:0])
                    3'd4:    n_size = {24'd0, b};
                    3'd5:    n_size = r_size | {16'd0, b, 8'd0};
                    3'd6:    n_size = r_size | {8'd0, b, 16'd0};
                    3'd7:    n_size = r_size | {b, 24'd0};
                    default: n_tag  = {r_tag[23:0], b};
                endcase
                n_cnt = r_cnt + 5'd1;
                if (r_cnt[2:0] == 3'd7) begin
                    n_cnt = 5'd0;
                    if (r_phase == whp_pkg::PH_FMT_HDR && r_tag == whp_pkg::TAG_FMT) begin
                        if (n_size < whp_pkg::FMT_BODY_LEN) begin
                            fail_req  = 1'b1;
                            fail_code = whp_pkg::ERR_SHORT_FMT;
                        end else begin
                            n_phase = whp_pkg::PH_FMT_BODY;
                        end
                    end else if (r_phase == whp_pkg::PH_DATA_HDR &&
                                 r_tag == whp_pkg::TAG_DATA) begin
                        n_pay = n_size;
                        if (n_size == 32'd0) begin
                            // empty payload finishes right at the header
                            if (r_rate == 32'd0) begin
                                fail_req  = 1'b1;
                                fail_code = whp_pkg::ERR_ZERO_RATE;
                            end else begin
                                done_req = 1'b1;
                            end
                        end else begin
                            n_phase = whp_pkg::PH_PAYLOAD;
                        end
                    end else if (n_size != 32'd0) begin
                        n_skip  = n_size;
                        n_phase = (r_phase == whp_pkg::PH_FMT_HDR) ?
                                  whp_pkg::PH_FMT_SKIP : whp_pkg::PH_DATA_SKIP;
                    end
                end
            end
            whp_pkg::PH_FMT_SKIP, whp_pkg::PH_DATA_SKIP, whp_pkg::PH_FMT_REST: begin
                n_skip = r_skip - 32'd1;
                if (n_skip == 32'd0) begin
                    n_cnt   = 5'd0;
                    n_phase = (r_phase == whp_pkg::PH_FMT_SKIP) ?
                              whp_pkg::PH_FMT_HDR : whp_pkg::PH_DATA_HDR;
                end
            end
            whp_pkg::PH_FMT_BODY: begin
                unique case (r_cnt)
                    5'd0:    n_fmt  = {8'd0, b};
                    5'd1:    n_fmt  = r_fmt | {b, 8'd0};
                    5'd2:    n_ch   = {8'd0, b};
                    5'd3:    n_ch   = r_ch | {b, 8'd0};
                    5'd4:    n_rate = {24'd0, b};
                    5'd5:    n_rate = r_rate | {16'd0, b, 8'd0};
                    5'd6:    n_rate = r_rate | {8'd0, b, 16'd0};
                    5'd7:    n_rate = r_rate | {b, 24'd0};
                    5'd14:   n_bits = {8'd0, b};
                    5'd15:   n_bits = r_bits | {b, 8'd0};
                    default: n_cnt  = r_cnt;
                endcase
                n_cnt = r_cnt + 5'd1;
                if (r_cnt >= 5'd15) begin
                    n_cnt = 5'd0;
                    if (n_fmt != whp_pkg::FMT_PCM && n_fmt != whp_pkg::FMT_EXTENSIBLE) begin
                        fail_req  = 1'b1;
                        fail_code = whp_pkg::ERR_FORMAT;
                    end else if (n_ch != 16'd1 && n_ch != 16'd2 && n_ch != 16'd4) begin
                        fail_req  = 1'b1;
                        fail_code = whp_pkg::ERR_CHANNELS;
                    end else if (n_bits != whp_pkg::BITS_REQUIRED) begin
                        fail_req  = 1'b1;
                        fail_code = whp_pkg::ERR_BITS;
                    end else begin
                        n_skip  = r_size - whp_pkg::FMT_BODY_LEN;
                        n_phase = (n_skip == 32'd0) ?
                                  whp_pkg::PH_DATA_HDR : whp_pkg::PH_FMT_REST;
                    end
                end
            end
            whp_pkg::PH_PAYLOAD: begin
                n_pay = r_pay - 32'd1;
                if (n_pay == 32'd0) begin
                    if (r_rate == 32'd0) begin
                        fail_req  = 1'b1;
                        fail_code = whp_pkg::ERR_ZERO_RATE;
                    end else begin
                        done_req = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // end of file while still parsing is truncation
        if (!fail_req && !done_req && r_verdict == whp_pkg::ST_PARSING &&
            i_item.end_of_file) begin
            fail_req  = 1'b1;
            fail_code = whp_pkg::ERR_TRUNCATED;
        end

        if (fail_req) begin
            n_verdict = whp_pkg::ST_FAILED;
            n_err     = fail_code;
            n_phase   = whp_pkg::PH_IDLE;
        end else if (done_req) begin
            n_verdict = whp_pkg::ST_DONE;
            n_err     = whp_pkg::ERR_NONE;
            n_phase   = whp_pkg::PH_IDLE;
        end
    end

    // result for this byte
    always_comb begin
        o_result.pcm_valid    = (r_phase == whp_pkg::PH_PAYLOAD);
        o_result.pcm_byte     = (r_phase == whp_pkg::PH_PAYLOAD) ? b : 8'd0;
        o_result.pcm_last     = (r_phase == whp_pkg::PH_PAYLOAD) && (r_pay == 32'd1);
        o_result.status       = n_verdict;
        o_result.error_code   = (n_verdict == whp_pkg::ST_FAILED) ? n_err : whp_pkg::ERR_NONE;
        o_result.num_channels = (n_verdict == whp_pkg::ST_DONE) ? n_ch[2:0] : 3'd0;
        o_result.rate_hz      = (n_verdict == whp_pkg::ST_DONE) ? n_rate : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= whp_pkg::PH_RIFF;
            r_verdict <= whp_pkg::ST_PARSING;
            r_cnt     <= 5'd0;
            r_tag     <= 32'd0;
            r_size    <= 32'd0;
            r_skip    <= 32'd0;
            r_pay     <= 32'd0;
            r_fmt     <= 16'd0;
            r_ch      <= 16'd0;
            r_rate    <= 32'd0;
            r_bits    <= 16'd0;
            r_err     <= whp_pkg::ERR_NONE;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_verdict <= n_verdict;
            r_cnt     <= n_cnt;
            r_tag     <= n_tag;
            r_size    <= n_size;
            r_skip    <= n_skip;
            r_pay     <= n_pay;
            r_fmt     <= n_fmt;
            r_ch      <= n_ch;
            r_rate    <= n_rate;
            r_bits    <= n_bits;
            r_err     <= n_err;
        end
    end

`ifndef ASSERT_OFF
    a_final_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_verdict != whp_pkg::ST_PARSING) |-> (r_phase == whp_pkg::PH_IDLE))
        else $error("finished verdict outside idle phase");

    a_verdict_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_verdict != whp_pkg::ST_PARSING) |=> $stable(r_verdict))
        else $error("verdict changed after finishing");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == whp_pkg::PH_PAYLOAD) |-> (r_pay != 32'd0))
        else $error("payload phase with nothing left");

    a_done_has_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_verdict == whp_pkg::ST_DONE) |-> (r_rate != 32'd0 && r_err == whp_pkg::ERR_NONE))
        else $error("done with zero rate or error code");
`endif

endmodule

`default_nettype wire

>>> rtl/whp_out_stage.sv
`default_nettype none

module whp_out_stage (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  whp_pkg::t_result  i_result,
    output logic              o_valid,
    input  wire               i_ready,
    output whp_pkg::t_result  o_result
);

    logic             r_valid;
    logic             n_valid;
    whp_pkg::t_result r_result;
    logic             w_load;

    // a held result frees the slot in the same cycle it is taken
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire
